// ----- hdl/ple_pkg.sv -----
// ---------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Holds the list capacity, derived widths, operation and status codes, and
// the command word that the controller broadcasts to the row of cells.
// ---------------------------------------------------------------------------
package ple_pkg;

    // Number of list entries, one cell each (legal range 2 to 64).
    localparam int CAPACITY = 16;

    // Widths of the word fields.
    localparam int ACTION_W   = 3;
    localparam int DATA_W     = 32;
    localparam int POSITION_W = 6;
    localparam int STATUS_W   = 3;
    localparam int ECOUNT_W   = 7;

    // Widths that follow from the capacity.
    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DATA_W-1:0] t_data;

    // Operation codes carried by the action field.
    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_END   = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_END   = 3'd4,
        ACT_DEL_POS   = 3'd5
    } t_action;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_USE_FRONT = 3'd3,
        ST_TOO_FEW   = 3'd4,
        ST_BAD_POS   = 3'd5,
        ST_USE_END   = 3'd6
    } t_status;

    // Command broadcast to every cell in the row.
    typedef struct packed {
        logic  ins;   // open a slot at idx and write word there
        logic  del;   // close the slot at idx
        t_idx  idx;
        t_data word;
    } t_cell_cmd;

endpackage

// ----- hdl/ple_cell.sv -----
// ---------------------------------------------------------------------------
// ple_cell: one list entry
// Holds one word. On an insert it takes the word from its lower neighbor or
// the new word; on a delete it takes the word from its upper neighbor.
// ---------------------------------------------------------------------------
module ple_cell (
    input  logic                i_clk,
    input  ple_pkg::t_cell_cmd  i_cmd,
    input  ple_pkg::t_idx       i_index,
    input  ple_pkg::t_data      i_lower,
    input  ple_pkg::t_data      i_upper,
    output ple_pkg::t_data      o_data,
    output ple_pkg::t_data      o_tap
);
    import ple_pkg::*;

    t_data r_data;
    t_data n_data;

    // Next word: shift up on insert, shift down on delete, else hold.
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (i_index == i_cmd.idx) begin
                n_data = i_cmd.word;
            end else if (i_index > i_cmd.idx) begin
                n_data = i_lower;
            end
        end else if (i_cmd.del) begin
            if (i_index >= i_cmd.idx) begin
                n_data = i_upper;
            end
        end
    end

    // Entry storage; contents are meaningless until written.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

    // The addressed cell offers its word for the removed-word reduction.
    assign o_tap = (i_cmd.del && (i_index == i_cmd.idx)) ? r_data : '0;

endmodule

// ----- hdl/ple_ctrl.sv -----
// ---------------------------------------------------------------------------
// ple_ctrl: operation decoder and occupancy counter
// Checks each word against the refusal rules, builds the cell command and
// keeps the number of valid entries.
// ---------------------------------------------------------------------------
module ple_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  logic [ple_pkg::ACTION_W-1:0]     i_action,
    input  ple_pkg::t_data                   i_value,
    input  logic [ple_pkg::POSITION_W-1:0]   i_position,
    output ple_pkg::t_cell_cmd               o_cmd,
    output ple_pkg::t_status                 o_status,
    output ple_pkg::t_cnt                    o_next_count
);
    import ple_pkg::*;

    t_cnt             r_count;
    t_cnt             n_count;
    logic [CMP_W-1:0] w_n;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_pos_m1;
    logic [CMP_W-1:0] w_n_m1;
    logic             w_full;
    logic             w_ins;
    logic             w_del;
    t_idx             w_idx;
    t_status          w_status;

    assign w_n      = CMP_W'(r_count);
    assign w_pos    = CMP_W'(i_position);
    assign w_pos_m1 = w_pos - CMP_W'(1);
    assign w_n_m1   = w_n - CMP_W'(1);
    assign w_full   = (w_n >= CMP_W'(CAPACITY));

    // Decode the action against the current occupancy.
    always_comb begin
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_idx    = '0;
        w_status = ST_OK;
        unique case (t_action'(i_action))
            ACT_INS_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            ACT_INS_END: begin
                if (w_n == '0) begin
                    w_status = ST_USE_FRONT;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    w_idx = w_n[IDX_W-1:0];
                end
            end
            ACT_INS_POS: begin
                if (w_n <= CMP_W'(1)) begin
                    w_status = ST_TOO_FEW;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos > CMP_W'(1) && w_pos <= w_n) begin
                    w_ins = 1'b1;
                    w_idx = w_pos_m1[IDX_W-1:0];
                end else begin
                    w_status = ST_BAD_POS;
                end
            end
            ACT_DEL_FRONT: begin
                if (w_n == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_del = 1'b1;
                end
            end
            ACT_DEL_END: begin
                if (w_n == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_n == CMP_W'(1)) begin
                    w_status = ST_USE_FRONT;
                end else begin
                    w_del = 1'b1;
                    w_idx = w_n_m1[IDX_W-1:0];
                end
            end
            ACT_DEL_POS: begin
                if (w_n == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_n == CMP_W'(1) || w_pos == CMP_W'(1)) begin
                    w_status = ST_USE_FRONT;
                end else if (w_pos > CMP_W'(1) && w_pos < w_n) begin
                    w_del = 1'b1;
                    w_idx = w_pos_m1[IDX_W-1:0];
                end else if (w_pos == w_n) begin
                    w_status = ST_USE_END;
                end else begin
                    w_status = ST_BAD_POS;
                end
            end
            default: begin
                // Unused action codes leave the list as it is.
            end
        endcase
    end

    // Occupancy after the operation.
    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + t_cnt'(1);
        end else if (w_del) begin
            n_count = r_count - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    // The cells only move on an accepted word.
    assign o_cmd.ins    = w_ins & i_fire;
    assign o_cmd.del    = w_del & i_fire;
    assign o_cmd.idx    = w_idx;
    assign o_cmd.word   = i_value;
    assign o_status     = w_status;
    assign o_next_count = n_count;

endmodule

// ----- hdl/positional_list_engine.sv -----
// ---------------------------------------------------------------------------
// positional_list_engine: bounded ordered list of signed 32-bit words
// Channel  Direction  Handshake                   Payload
// in       input      i_in_valid / o_in_ready     action, value, position
// out      output     o_out_valid / i_out_ready   status, removed_value,
//                                                 entry_count
// The row of cells shifts every entry in parallel, so any insert or delete
// completes at the accepting edge. The result sits in an output register;
// a new word is taken whenever that register is empty or is being read in
// the same cycle.
// Reset clears the occupancy count and the output valid flag; the cells
// are never cleared and hold no meaning above the count.
// ---------------------------------------------------------------------------
module positional_list_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ple_pkg::ACTION_W-1:0]      i_action,
    input  logic signed [ple_pkg::DATA_W-1:0] i_value,
    input  logic [ple_pkg::POSITION_W-1:0]    i_position,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ple_pkg::STATUS_W-1:0]      o_status,
    output logic signed [ple_pkg::DATA_W-1:0] o_removed_value,
    output logic [ple_pkg::ECOUNT_W-1:0]      o_entry_count
);
    import ple_pkg::*;

    logic      w_fire;
    t_cell_cmd w_cmd;
    t_status   w_status;
    t_cnt      w_next_count;
    t_data     w_data [CAPACITY];
    t_data     w_tap  [CAPACITY];
    t_data     w_removed;

    logic                r_out_valid;
    logic                n_out_valid;
    logic [STATUS_W-1:0] r_status;
    t_data               r_removed;
    t_cnt                r_count;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign w_fire     = i_in_valid & o_in_ready;

    // Decoder and occupancy count.
    ple_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_action     (i_action),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_cmd        (w_cmd),
        .o_status     (w_status),
        .o_next_count (w_next_count)
    );

    // Row of cells, entry 1 in cell 0; each inner cell sees both neighbors.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_data w_lower;
        t_data w_upper;
        if (k == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_upper = w_data[k];
        end else begin : g_mid_hi
            assign w_upper = w_data[k+1];
        end
        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (t_idx'(k)),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_data  (w_data[k]),
            .o_tap   (w_tap[k])
        );
    end

    // Only the addressed cell taps out its word on a delete; all others give zero.
    always_comb begin
        w_removed = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_removed = w_removed | w_tap[k];
        end
    end

    // Output valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status  <= w_status;
            r_removed <= w_removed;
            r_count   <= w_next_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_entry_count   = ECOUNT_W'(r_count);

endmodule

// ----- sim/positional_list_engine_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_list_engine_tb: self-checking bench for the positional list engine
// A short table of directed words walks the empty, single-entry and refusal
// cases, then random words in four handshake phases grow, shrink and churn
// the list, including long stretches against a full list. Each accepted word
// is run through a local list model, and every output word is compared
// field by field with the oldest predicted result.
// ---------------------------------------------------------------------------
module positional_list_engine_tb;

    import ple_pkg::*;

    localparam int  ITEMS_PER_PHASE = 450;
    localparam int  LIMIT_CYCLES    = 200_000;
    localparam int  SETTLE_CYCLES   = 8;
    localparam int  MAX_REPORTS     = 30;

    // Action codes that the block treats as no operation.
    localparam logic [ACTION_W-1:0] ACT_NOP_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_NOP_7 = 3'd7;

    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] WORD_NEG = 32'hFFFF_FFFF;

    // One result word as the block reports it.
    typedef struct packed {
        t_status               status;
        logic [DATA_W-1:0]     removed;
        logic [ECOUNT_W-1:0]   count;
    } t_list_result;

    // One row of the directed table; typed rows carry their own result.
    typedef struct packed {
        logic [ACTION_W-1:0]   act;
        logic [DATA_W-1:0]     val;
        logic [POSITION_W-1:0] pos;
        logic                  typed;
        t_list_result          res;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 23;
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        // Empty list: every delete, the refused inserts and the unused codes.
        '{ACT_DEL_FRONT, 32'd0, 6'd0,  1'b1, '{ST_EMPTY,     32'd0, 7'd0}},
        '{ACT_DEL_END,   32'd0, 6'd0,  1'b1, '{ST_EMPTY,     32'd0, 7'd0}},
        '{ACT_DEL_POS,   32'd0, 6'd0,  1'b1, '{ST_EMPTY,     32'd0, 7'd0}},
        '{ACT_INS_END,   32'd5, 6'd1,  1'b1, '{ST_USE_FRONT, 32'd0, 7'd0}},
        '{ACT_INS_POS,   32'd5, 6'd1,  1'b1, '{ST_TOO_FEW,   32'd0, 7'd0}},
        '{ACT_NOP_6,     32'd9, 6'd63, 1'b1, '{ST_OK,        32'd0, 7'd0}},
        '{ACT_NOP_7,     32'd9, 6'd1,  1'b1, '{ST_OK,        32'd0, 7'd0}},
        // One entry.
        '{ACT_INS_FRONT, WORD_MIN, 6'd0, 1'b1, '{ST_OK,        32'd0, 7'd1}},
        '{ACT_INS_POS,   32'd3,    6'd1, 1'b1, '{ST_TOO_FEW,   32'd0, 7'd1}},
        '{ACT_DEL_END,   32'd0,    6'd0, 1'b1, '{ST_USE_FRONT, 32'd0, 7'd1}},
        '{ACT_DEL_POS,   32'd0,    6'd2, 1'b1, '{ST_USE_FRONT, 32'd0, 7'd1}},
        // Grow to three entries and probe the position rules.
        '{ACT_INS_END,   WORD_MAX, 6'd0,  1'b1, '{ST_OK,        32'd0, 7'd2}},
        '{ACT_INS_POS,   WORD_NEG, 6'd2,  1'b1, '{ST_OK,        32'd0, 7'd3}},
        '{ACT_INS_POS,   32'd1,    6'd0,  1'b1, '{ST_BAD_POS,   32'd0, 7'd3}},
        '{ACT_INS_POS,   32'd1,    6'd63, 1'b1, '{ST_BAD_POS,   32'd0, 7'd3}},
        '{ACT_INS_POS,   32'd1,    6'd4,  1'b1, '{ST_BAD_POS,   32'd0, 7'd3}},
        '{ACT_DEL_POS,   32'd0,    6'd1,  1'b1, '{ST_USE_FRONT, 32'd0, 7'd3}},
        '{ACT_DEL_POS,   32'd0,    6'd3,  1'b1, '{ST_USE_END,   32'd0, 7'd3}},
        '{ACT_DEL_POS,   32'd0,    6'd0,  1'b1, '{ST_BAD_POS,   32'd0, 7'd3}},
        '{ACT_DEL_POS,   32'd0,    6'd63, 1'b1, '{ST_BAD_POS,   32'd0, 7'd3}},
        // Take the three words back out, middle first.
        '{ACT_DEL_POS,   32'd0, 6'd2, 1'b1, '{ST_OK, WORD_NEG, 7'd2}},
        '{ACT_DEL_END,   32'd0, 6'd0, 1'b1, '{ST_OK, WORD_MAX, 7'd1}},
        '{ACT_DEL_FRONT, 32'd0, 6'd0, 1'b1, '{ST_OK, WORD_MIN, 7'd0}}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [ACTION_W-1:0]           i_action = '0;
    logic signed [DATA_W-1:0]      i_value = '0;
    logic [POSITION_W-1:0]         i_position = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [STATUS_W-1:0]           o_status;
    logic signed [DATA_W-1:0]      o_removed_value;
    logic [ECOUNT_W-1:0]           o_entry_count;

    // List model and the results it has predicted but not yet seen.
    logic [DATA_W-1:0] model_words [CAPACITY];
    int                model_len = 0;
    t_list_result      pending_results [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    positional_list_engine u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_entry_count   (o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Open a slot at idx by shifting the tail up, then write the word there.
    function automatic void model_insert(input int idx, input logic [DATA_W-1:0] w);
        for (int i = model_len; i > idx; i--) begin
            model_words[i] = model_words[i-1];
        end
        model_words[idx] = w;
        model_len++;
    endfunction

    // Close the slot at idx by shifting the tail down; returns the old word.
    function automatic logic [DATA_W-1:0] model_remove(input int idx);
        logic [DATA_W-1:0] w;
        w = model_words[idx];
        for (int i = idx; i + 1 < model_len; i++) begin
            model_words[i] = model_words[i+1];
        end
        model_len--;
        return w;
    endfunction

    // Apply one list operation to the model and return the result it gives.
    function automatic t_list_result apply_list_op(input logic [ACTION_W-1:0] act,
                                                   input logic [DATA_W-1:0] val,
                                                   input logic [POSITION_W-1:0] pos);
        t_list_result res;
        int n;
        int p;
        n = model_len;
        p = int'(pos);
        res.status = ST_OK;
        res.removed = '0;
        case (act)
            ACT_INS_FRONT: begin
                if (n >= CAPACITY) res.status = ST_FULL;
                else model_insert(0, val);
            end
            ACT_INS_END: begin
                if (n == 0) res.status = ST_USE_FRONT;
                else if (n >= CAPACITY) res.status = ST_FULL;
                else model_insert(n, val);
            end
            ACT_INS_POS: begin
                if (n <= 1) res.status = ST_TOO_FEW;
                else if (n >= CAPACITY) res.status = ST_FULL;
                else if (p > 1 && p <= n) model_insert(p - 1, val);
                else res.status = ST_BAD_POS;
            end
            ACT_DEL_FRONT: begin
                if (n == 0) res.status = ST_EMPTY;
                else res.removed = model_remove(0);
            end
            ACT_DEL_END: begin
                if (n == 0) res.status = ST_EMPTY;
                else if (n == 1) res.status = ST_USE_FRONT;
                else res.removed = model_remove(n - 1);
            end
            ACT_DEL_POS: begin
                if (n == 0) res.status = ST_EMPTY;
                else if (n == 1 || p == 1) res.status = ST_USE_FRONT;
                else if (p > 1 && p < n) res.removed = model_remove(p - 1);
                else if (p == n) res.status = ST_USE_END;
                else res.status = ST_BAD_POS;
            end
            default: begin
                // Unused action codes leave the list alone.
            end
        endcase
        res.count = ECOUNT_W'(model_len);
        return res;
    endfunction

    // Present one word, wait for it to be taken, and record its result.
    task automatic send_word(input logic [ACTION_W-1:0] act,
                             input logic [DATA_W-1:0] val,
                             input logic [POSITION_W-1:0] pos,
                             input logic typed,
                             input t_list_result typed_res);
        t_list_result res;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_value <= val;
        i_position <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        res = apply_list_op(act, val, pos);
        if (typed) res = typed_res;
        pending_results.push_back(res);
    endtask

    // Hold the input side idle until every predicted result has arrived.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Draw a random word; grow mode favors inserts, shrink mode deletes.
    task automatic pick_word(input int mode,
                             output logic [ACTION_W-1:0] act,
                             output logic [DATA_W-1:0] val,
                             output logic [POSITION_W-1:0] pos);
        int insert_pct;
        insert_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
        if ($urandom_range(99) < 4) begin
            act = ($urandom_range(1) != 0) ? ACT_NOP_7 : ACT_NOP_6;
        end else if ($urandom_range(99) < insert_pct) begin
            case ($urandom_range(2))
                0: act = ACT_INS_FRONT;
                1: act = ACT_INS_END;
                default: act = ACT_INS_POS;
            endcase
        end else begin
            case ($urandom_range(2))
                0: act = ACT_DEL_FRONT;
                1: act = ACT_DEL_END;
                default: act = ACT_DEL_POS;
            endcase
        end
        case ($urandom_range(19))
            0: val = WORD_MIN;
            1: val = WORD_MAX;
            2: val = WORD_NEG;
            3: val = '0;
            default: val = $urandom;
        endcase
        // Mostly positions around the live range, so the shifts get exercised.
        if ($urandom_range(3) != 0) pos = POSITION_W'($urandom_range(model_len + 1));
        else pos = POSITION_W'($urandom_range(63));
    endtask

    // The receiver drops ready at random according to the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Compare each output word with the oldest prediction.
    always @(posedge i_clk) begin
        t_list_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result word: status %0d removed %0d count %0d",
                             $time, o_status, o_removed_value, o_entry_count);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, exp_res.status, o_status);
                end
                if (o_removed_value !== exp_res.removed) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: removed value mismatch: expected %0d actual %0d",
                                 $time, $signed(exp_res.removed), o_removed_value);
                end
                if (o_entry_count !== exp_res.count) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: entry count mismatch: expected %0d actual %0d",
                                 $time, exp_res.count, o_entry_count);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [ACTION_W-1:0]   act;
        logic [DATA_W-1:0]     val;
        logic [POSITION_W-1:0] pos;
        int                    mode;
        int                    sent;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, no idling on either side.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_word(DIRECTED[r].act, DIRECTED[r].val, DIRECTED[r].pos,
                      DIRECTED[r].typed, DIRECTED[r].res);
        end
        drain_results();

        // Random words in four phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
                default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
            endcase
            mode = 0;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(31) == 0) mode = $urandom_range(2);
                pick_word(mode, act, val, pos);
                send_word(act, val, pos, 1'b0, '0);
                if (act <= ACT_DEL_POS) sent++;
            end
            // Let the output side run dry before the next phase starts.
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
